[rtl/core/rgb_nearest_centroid_classifier_assert.svh]
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - assertion macros
// Short forms for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RGB_NEAREST_CENTROID_CLASSIFIER_ASSERT_SVH
`define RGB_NEAREST_CENTROID_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/rnc_pkg.sv]
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - package
// Shared constants, class codes and register indexes.
// ----------------------------------------------------------------------------
package rnc_pkg;

   localparam int NUM_CENTROIDS   = 5;
   localparam int NUM_CH          = 3;
   localparam int FRAC_BITS_DEF   = 10;
   localparam int LEVEL_BITS_DEF  = 16;
   localparam int IN_LEVEL_W      = 16;
   localparam int REQ_TDATA_W     = 3 * IN_LEVEL_W;
   localparam int RSP_TDATA_W     = 8;
   localparam int CLASS_W         = 3;
   localparam int CSR_ADDR_W      = 3;
   localparam int CENTROID_RST_W  = 30;

   // Default centroids, r << 20 | g << 10 | b in Q0.10.
   localparam logic [CENTROID_RST_W-1:0] CENTROID_RESET [NUM_CENTROIDS] = '{
      30'd483676467, 30'd268918057, 30'd268760525, 30'd344383744, 30'd354765138
   };

   typedef enum logic [CLASS_W-1:0] {
      CLS_BLACK  = 3'd0,
      CLS_RED    = 3'd1,
      CLS_GREEN  = 3'd2,
      CLS_PURPLE = 3'd3,
      CLS_YELLOW = 3'd4,
      CLS_WHITE  = 3'd5
   } class_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CENTROID_RED    = 3'd0,
      CSR_CENTROID_GREEN  = 3'd1,
      CSR_CENTROID_PURPLE = 3'd2,
      CSR_CENTROID_YELLOW = 3'd3,
      CSR_CENTROID_WHITE  = 3'd4
   } csr_idx_type;

endpackage

[rtl/core/rnc_front.sv]
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - front stages
// Channel sum and the centroid-by-sum products for all five centroids.
// ----------------------------------------------------------------------------
module rnc_front #(
   parameter int FRAC_BITS  = rnc_pkg::FRAC_BITS_DEF,
   parameter int LEVEL_BITS = rnc_pkg::LEVEL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [LEVEL_BITS-1:0]       in_level [rnc_pkg::NUM_CH],
   input  logic                        in_read_ok,
   input  logic [3*FRAC_BITS-1:0]      centroid [rnc_pkg::NUM_CENTROIDS],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [LEVEL_BITS-1:0]       out_level [rnc_pkg::NUM_CH],
   output logic [FRAC_BITS+LEVEL_BITS+1:0]
                                       out_prod [rnc_pkg::NUM_CENTROIDS][rnc_pkg::NUM_CH],
   output logic                        out_force,
   output rnc_pkg::class_type          out_cls
);
   import rnc_pkg::*;

   localparam int SUM_W  = LEVEL_BITS + 2;
   localparam int PROD_W = FRAC_BITS + SUM_W;

   logic                  v1_ff, v1_in, v2_ff, v2_in;
   logic                  ready1, ready2;
   logic [LEVEL_BITS-1:0] lvl1_ff [NUM_CH];
   logic [LEVEL_BITS-1:0] lvl1_in [NUM_CH];
   logic [SUM_W-1:0]      sum1_ff, sum1_in;
   logic                  force1_ff, force1_in, force2_ff;
   class_type             cls1_ff, cls1_in, cls2_ff;
   logic [LEVEL_BITS-1:0] lvl2_ff [NUM_CH];
   logic [PROD_W-1:0]     prod2_ff [NUM_CENTROIDS][NUM_CH];
   logic [PROD_W-1:0]     prod2_in [NUM_CENTROIDS][NUM_CH];

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;
   assign v1_in    = in_valid;
   assign v2_in    = v1_ff;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         lvl1_in[ch] = in_level[ch];
      end
      sum1_in = SUM_W'(in_level[0]) + SUM_W'(in_level[1]) + SUM_W'(in_level[2]);
      // A failed read wins over a dark reading.
      force1_in = !in_read_ok || (sum1_in == '0);
      cls1_in   = in_read_ok ? CLS_BLACK : CLS_WHITE;
   end

   always_comb begin
      for (int i = 0; i < NUM_CENTROIDS; i++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            prod2_in[i][ch] =
               PROD_W'(centroid[i][(NUM_CH-1-ch)*FRAC_BITS +: FRAC_BITS]) *
               PROD_W'(sum1_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= v1_in;
         end
         if (ready2) begin
            v2_ff <= v2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         lvl1_ff   <= lvl1_in;
         sum1_ff   <= sum1_in;
         force1_ff <= force1_in;
         cls1_ff   <= cls1_in;
      end
      if (ready2) begin
         lvl2_ff   <= lvl1_ff;
         prod2_ff  <= prod2_in;
         force2_ff <= force1_ff;
         cls2_ff   <= cls1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_level = lvl2_ff;
   assign out_prod  = prod2_ff;
   assign out_force = force2_ff;
   assign out_cls   = cls2_ff;

endmodule

[rtl/core/rnc_dist.sv]
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - distance stages
// Per-channel absolute differences, then the scaled L1 distance per centroid.
// ----------------------------------------------------------------------------
module rnc_dist #(
   parameter int FRAC_BITS  = rnc_pkg::FRAC_BITS_DEF,
   parameter int LEVEL_BITS = rnc_pkg::LEVEL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [LEVEL_BITS-1:0]       in_level [rnc_pkg::NUM_CH],
   input  logic [FRAC_BITS+LEVEL_BITS+1:0]
                                       in_prod [rnc_pkg::NUM_CENTROIDS][rnc_pkg::NUM_CH],
   input  logic                        in_force,
   input  rnc_pkg::class_type          in_cls,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [FRAC_BITS+LEVEL_BITS+3:0] out_dist [rnc_pkg::NUM_CENTROIDS],
   output logic                        out_force,
   output rnc_pkg::class_type          out_cls
);
   import rnc_pkg::*;

   localparam int PROD_W = FRAC_BITS + LEVEL_BITS + 2;
   localparam int DIST_W = PROD_W + 2;

   logic              v3_ff, v3_in, v4_ff, v4_in;
   logic              ready3, ready4;
   logic [PROD_W-1:0] lvl_sh [NUM_CH];
   logic [PROD_W-1:0] diff3_ff [NUM_CENTROIDS][NUM_CH];
   logic [PROD_W-1:0] diff3_in [NUM_CENTROIDS][NUM_CH];
   logic [DIST_W-1:0] dist4_ff [NUM_CENTROIDS];
   logic [DIST_W-1:0] dist4_in [NUM_CENTROIDS];
   logic              force3_ff, force4_ff;
   class_type         cls3_ff, cls4_ff;

   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign in_ready = ready3;
   assign v3_in    = in_valid;
   assign v4_in    = v3_ff;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         lvl_sh[ch] = PROD_W'(in_level[ch]) << FRAC_BITS;
      end
      for (int i = 0; i < NUM_CENTROIDS; i++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            diff3_in[i][ch] = (lvl_sh[ch] >= in_prod[i][ch]) ?
                              (lvl_sh[ch] - in_prod[i][ch]) :
                              (in_prod[i][ch] - lvl_sh[ch]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CENTROIDS; i++) begin
         dist4_in[i] = DIST_W'(diff3_ff[i][0]) + DIST_W'(diff3_ff[i][1]) +
                       DIST_W'(diff3_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready3) begin
            v3_ff <= v3_in;
         end
         if (ready4) begin
            v4_ff <= v4_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         diff3_ff  <= diff3_in;
         force3_ff <= in_force;
         cls3_ff   <= in_cls;
      end
      if (ready4) begin
         dist4_ff  <= dist4_in;
         force4_ff <= force3_ff;
         cls4_ff   <= cls3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_dist  = dist4_ff;
   assign out_force = force4_ff;
   assign out_cls   = cls4_ff;

endmodule

[rtl/core/rnc_select.sv]
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - selection stages
// Registered minimum tree over the five distances; the last stage is the
// output register.
// ----------------------------------------------------------------------------
module rnc_select #(
   parameter int FRAC_BITS  = rnc_pkg::FRAC_BITS_DEF,
   parameter int LEVEL_BITS = rnc_pkg::LEVEL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [FRAC_BITS+LEVEL_BITS+3:0] in_dist [rnc_pkg::NUM_CENTROIDS],
   input  logic                        in_force,
   input  rnc_pkg::class_type          in_cls,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rnc_pkg::class_type          out_cls
);
   import rnc_pkg::*;

   localparam int DIST_W = FRAC_BITS + LEVEL_BITS + 4;

   logic              v5_ff, v5_in, v6_ff, v6_in;
   logic              ready5, ready6;
   logic [DIST_W-1:0] d01_ff, d01_in, d23_ff, d23_in, d4_ff, d_mid;
   class_type         c01_ff, c01_in, c23_ff, c23_in, c_mid;
   logic              force5_ff;
   class_type         cls5_ff, cls6_ff, cls6_in;

   assign ready6   = !v6_ff || out_ready;
   assign ready5   = !v5_ff || ready6;
   assign in_ready = ready5;
   assign v5_in    = in_valid;
   assign v6_in    = v5_ff;

   // A later centroid replaces an earlier one only when strictly closer.
   always_comb begin
      if (in_dist[1] < in_dist[0]) begin
         d01_in = in_dist[1];
         c01_in = CLS_GREEN;
      end else begin
         d01_in = in_dist[0];
         c01_in = CLS_RED;
      end
      if (in_dist[3] < in_dist[2]) begin
         d23_in = in_dist[3];
         c23_in = CLS_YELLOW;
      end else begin
         d23_in = in_dist[2];
         c23_in = CLS_PURPLE;
      end
   end

   always_comb begin
      if (d23_ff < d01_ff) begin
         d_mid = d23_ff;
         c_mid = c23_ff;
      end else begin
         d_mid = d01_ff;
         c_mid = c01_ff;
      end
      if (force5_ff) begin
         cls6_in = cls5_ff;
      end else if (d4_ff < d_mid) begin
         cls6_in = CLS_WHITE;
      end else begin
         cls6_in = c_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (ready5) begin
            v5_ff <= v5_in;
         end
         if (ready6) begin
            v6_ff <= v6_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready5) begin
         d01_ff    <= d01_in;
         c01_ff    <= c01_in;
         d23_ff    <= d23_in;
         c23_ff    <= c23_in;
         d4_ff     <= in_dist[4];
         force5_ff <= in_force;
         cls5_ff   <= in_cls;
      end
      if (ready6) begin
         cls6_ff <= cls6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_cls   = cls6_ff;

endmodule

[rtl/core/rgb_nearest_centroid_classifier.sv]
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - top level
// Classifies one red/green/blue light reading to the nearest color centroid.
// ----------------------------------------------------------------------------
// A request carries three raw channel counts on req_tdata and the read-ok
// flag on req_tuser. Each request gives exactly one response whose tdata
// holds the class: black, red, green, purple, yellow or white.
// The five centroids are written through the csr_ port, one register per
// index; writes take effect at once and should be made while idle.
// The datapath is a six-stage pipeline: sum, products, differences,
// distances, pair minimum, final minimum. rsp_tvalid is the valid flag of
// the final minimum stage register. One request is taken every cycle
// while rsp_tready is high; each stage holds its item when the next one
// is full, so a stalled rsp_tready lets the stages fill; req_tready falls
// only when all six hold an item. Reset empties the pipeline and loads
// the default centroids.
// ----------------------------------------------------------------------------
module rgb_nearest_centroid_classifier #(
   parameter int FRAC_BITS  = rnc_pkg::FRAC_BITS_DEF,
   parameter int LEVEL_BITS = rnc_pkg::LEVEL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // red_level, green_level, blue_level (low to high)
   input  logic [rnc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // read_ok
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // color_class, zero padding
   output logic [rnc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [rnc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [3*FRAC_BITS-1:0]           csr_wdata
);
   import rnc_pkg::*;

   localparam int CFG_W  = 3 * FRAC_BITS;
   localparam int PROD_W = FRAC_BITS + LEVEL_BITS + 2;
   localparam int DIST_W = PROD_W + 2;

   logic [CFG_W-1:0]      centroid_ff [NUM_CENTROIDS];
   logic [LEVEL_BITS-1:0] req_level [NUM_CH];

   logic                  front_valid, front_ready;
   logic [LEVEL_BITS-1:0] front_level [NUM_CH];
   logic [PROD_W-1:0]     front_prod [NUM_CENTROIDS][NUM_CH];
   logic                  front_force;
   class_type             front_cls;

   logic                  dist_valid, dist_ready;
   logic [DIST_W-1:0]     dist_dist [NUM_CENTROIDS];
   logic                  dist_force;
   class_type             dist_cls;

   class_type             sel_cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CENTROIDS; i++) begin
            centroid_ff[i] <= CFG_W'(CENTROID_RESET[i]);
         end
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_CENTROID_RED: begin
               centroid_ff[0] <= csr_wdata;
            end
            CSR_CENTROID_GREEN: begin
               centroid_ff[1] <= csr_wdata;
            end
            CSR_CENTROID_PURPLE: begin
               centroid_ff[2] <= csr_wdata;
            end
            CSR_CENTROID_YELLOW: begin
               centroid_ff[3] <= csr_wdata;
            end
            CSR_CENTROID_WHITE: begin
               centroid_ff[4] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         req_level[ch] = req_tdata[ch*IN_LEVEL_W +: LEVEL_BITS];
      end
   end

   rnc_front #(
      .FRAC_BITS  (FRAC_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_level   (req_level),
      .in_read_ok (req_tuser),
      .centroid   (centroid_ff),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_level  (front_level),
      .out_prod   (front_prod),
      .out_force  (front_force),
      .out_cls    (front_cls)
   );

   rnc_dist #(
      .FRAC_BITS  (FRAC_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_level  (front_level),
      .in_prod   (front_prod),
      .in_force  (front_force),
      .in_cls    (front_cls),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_dist  (dist_dist),
      .out_force (dist_force),
      .out_cls   (dist_cls)
   );

   rnc_select #(
      .FRAC_BITS  (FRAC_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_ready  (dist_ready),
      .in_dist   (dist_dist),
      .in_force  (dist_force),
      .in_cls    (dist_cls),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cls   (sel_cls)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-CLASS_W){1'b0}}, sel_cls};

`include "rgb_nearest_centroid_classifier_assert.svh"

   // An empty or draining output stage must open the whole pipeline.
   `RNC_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_tvalid || rsp_tready, req_tready, "pipeline blocks requests while output drains")
   // An item held at the distance stage is never dropped.
   `RNC_ASSERT_NEXT(a_dist_hold, clock, reset, dist_valid && !dist_ready, dist_valid, "distance stage lost a stalled request")
   // Only the six defined class codes leave the block.
   `RNC_ASSERT_NOW(a_class_range, clock, reset, rsp_tvalid, rsp_tdata <= RSP_TDATA_W'(CLS_WHITE), "class code out of range")

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB nearest centroid classifier - testbench
// Sends raw light readings and checks each color class against a predictor
// that recomputes the sum-scaled L1 distance to every centroid in 64 bits.
// ----------------------------------------------------------------------------
module testbench;
   import rnc_pkg::*;

   localparam int FRAC_BITS        = FRAC_BITS_DEF;
   localparam int CENTROID_W       = 3 * FRAC_BITS;
   localparam int DIST_START_BOUND = 100;
   localparam int IDLE_PERCENT     = 38;
   localparam int PIPE_SETTLE      = 20;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_REQUESTS   = 110;
   localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
   localparam logic [CENTROID_W-1:0] CENTROID_ALL_ONES = '1;

   localparam csr_idx_type CENTROID_CSR [NUM_CENTROIDS] = '{
      CSR_CENTROID_RED, CSR_CENTROID_GREEN, CSR_CENTROID_PURPLE,
      CSR_CENTROID_YELLOW, CSR_CENTROID_WHITE
   };
   localparam class_type CENTROID_CLASS [NUM_CENTROIDS] = '{
      CLS_RED, CLS_GREEN, CLS_PURPLE, CLS_YELLOW, CLS_WHITE
   };

   typedef struct packed {
      logic [IN_LEVEL_W-1:0] red;
      logic [IN_LEVEL_W-1:0] green;
      logic [IN_LEVEL_W-1:0] blue;
      logic                  read_ok;
   } light_reading_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CENTROID_W-1:0]   csr_wdata  = '0;

   logic [CENTROID_W-1:0]   centroid_model [NUM_CENTROIDS];
   class_type               expected_class_q [$];
   bit                      idle_enable   = 1'b1;
   int                      rsp_hold_left = 0;
   int                      error_count   = 0;
   int                      cycle_count   = 0;

   rgb_nearest_centroid_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Nearest centroid under the L1 distance, every term scaled by the sum.
   function automatic class_type nearest_class(light_reading_type rd);
      logic [63:0] level [NUM_CH];
      logic [63:0] total;
      logic [63:0] best;
      logic [63:0] l1_sum;
      logic [63:0] frac;
      logic [63:0] scaled;
      class_type   pick;
      level[0] = 64'(rd.red);
      level[1] = 64'(rd.green);
      level[2] = 64'(rd.blue);
      if (!rd.read_ok) return CLS_WHITE;
      total = level[0] + level[1] + level[2];
      if (total == 64'd0) return CLS_BLACK;
      best = (64'(DIST_START_BOUND) << FRAC_BITS) * total;
      pick = CLS_BLACK;
      for (int k = 0; k < NUM_CENTROIDS; k++) begin
         l1_sum = 64'd0;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            frac   = (64'(centroid_model[k]) >> ((2 - ch) * FRAC_BITS)) & FRAC_MASK;
            scaled = frac * total;
            l1_sum += ((level[ch] << FRAC_BITS) >= scaled) ?
                      (level[ch] << FRAC_BITS) - scaled : scaled - (level[ch] << FRAC_BITS);
         end
         if (l1_sum < best) begin
            best = l1_sum;
            pick = CENTROID_CLASS[k];
         end
      end
      return pick;
   endfunction

   function automatic light_reading_type random_reading();
      light_reading_type rd;
      int                mode;
      int                k;
      int                scale;
      int                lvl [NUM_CH];
      mode       = $urandom_range(99);
      rd.read_ok = 1'b1;
      if (mode < 10) begin
         rd         = light_reading_type'({$urandom(), $urandom()});
         rd.read_ok = 1'b0;
      end else if (mode < 20) begin
         // Tiny counts give zero sums and many exact ties.
         rd.red   = IN_LEVEL_W'($urandom_range(3));
         rd.green = IN_LEVEL_W'($urandom_range(3));
         rd.blue  = IN_LEVEL_W'($urandom_range(3));
      end else if (mode < 40) begin
         rd.red   = IN_LEVEL_W'($urandom());
         rd.green = IN_LEVEL_W'($urandom());
         rd.blue  = IN_LEVEL_W'($urandom());
      end else if (mode < 60) begin
         rd.red   = IN_LEVEL_W'($urandom() & ((32'd1 << $urandom_range(16)) - 1));
         rd.green = IN_LEVEL_W'($urandom() & ((32'd1 << $urandom_range(16)) - 1));
         rd.blue  = IN_LEVEL_W'($urandom() & ((32'd1 << $urandom_range(16)) - 1));
      end else begin
         // Readings scattered around one of the current centroids.
         k     = $urandom_range(NUM_CENTROIDS - 1);
         scale = $urandom_range(1, 60);
         for (int ch = 0; ch < NUM_CH; ch++) begin
            lvl[ch] = int'((centroid_model[k] >> ((2 - ch) * FRAC_BITS)) & FRAC_MASK) * scale
                      + $urandom_range(scale * 40);
            if (lvl[ch] > 65535) lvl[ch] = 65535;
         end
         rd.red   = IN_LEVEL_W'(lvl[0]);
         rd.green = IN_LEVEL_W'(lvl[1]);
         rd.blue  = IN_LEVEL_W'(lvl[2]);
      end
      return rd;
   endfunction

   task automatic send_reading(light_reading_type rd);
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rd.blue, rd.green, rd.red};
      req_tuser  <= rd.read_ok;
      do @(posedge clock); while (!req_tready);
      expected_class_q.push_back(nearest_class(rd));
   endtask

   task automatic send_levels(int red, int green, int blue, bit read_ok);
      light_reading_type rd;
      rd = '{IN_LEVEL_W'(red), IN_LEVEL_W'(green), IN_LEVEL_W'(blue), read_ok};
      send_reading(rd);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (expected_class_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_centroid(logic [CSR_ADDR_W-1:0] index, logic [CENTROID_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index < NUM_CENTROIDS) centroid_model[index] = value;
   endtask

   task automatic test_reset_centroids();
      send_levels(0, 0, 0, 1'b1);
      send_levels(0, 0, 0, 1'b0);
      send_levels(65535, 65535, 65535, 1'b0);
      send_levels(65535, 65535, 65535, 1'b1);
      send_levels(65535, 0, 0, 1'b1);
      send_levels(0, 65535, 0, 1'b1);
      send_levels(0, 0, 65535, 1'b1);
      send_levels(1, 0, 0, 1'b1);
      send_levels(0, 0, 1, 1'b1);
      send_levels(65535, 65535, 0, 1'b1);
      send_levels(461, 276, 307, 1'b1);
      send_levels(32768, 1234, 65535, 1'b1);
      wait_for_responses();
   endtask

   // With identical centroids the earliest one must win every time.
   task automatic test_tie_break();
      logic [CENTROID_W-1:0] shared;
      shared = CENTROID_W'($urandom());
      for (int k = 0; k < NUM_CENTROIDS; k++) write_centroid(CENTROID_CSR[k], shared);
      send_levels(100, 200, 300, 1'b1);
      send_levels(65535, 1, 65535, 1'b1);
      send_levels(1, 1, 1, 1'b1);
      send_levels(0, 7, 0, 1'b1);
      wait_for_responses();
   endtask

   task automatic test_centroid_extremes();
      write_centroid(CSR_CENTROID_RED, '0);
      write_centroid(CSR_CENTROID_GREEN, CENTROID_ALL_ONES);
      write_centroid(CSR_CENTROID_PURPLE, CENTROID_W'(30'h1555_5555));
      write_centroid(CSR_CENTROID_YELLOW, '0);
      write_centroid(CSR_CENTROID_WHITE, CENTROID_ALL_ONES);
      send_levels(65535, 65535, 65535, 1'b1);
      send_levels(65535, 0, 0, 1'b1);
      send_levels(0, 1, 65535, 1'b1);
      send_levels(3, 3, 0, 1'b1);
      wait_for_responses();
   endtask

   // Writes to indexes past the last centroid must leave every centroid alone.
   task automatic test_unused_csr_index();
      for (int idx = NUM_CENTROIDS; idx < 2 ** CSR_ADDR_W; idx++) begin
         write_centroid(CSR_ADDR_W'(idx), CENTROID_W'($urandom()));
      end
      send_levels(65535, 65535, 65535, 1'b1);
      send_levels(12, 40000, 9, 1'b1);
      send_levels(500, 300, 200, 1'b1);
      wait_for_responses();
   endtask

   task automatic test_random_centroids();
      logic [CENTROID_W-1:0] value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int k = 0; k < NUM_CENTROIDS; k++) begin
            case (phase % 4)
               0: value = CENTROID_RESET[k];
               1: value = {10'($urandom_range(150, 500)), 10'($urandom_range(150, 500)),
                           10'($urandom_range(150, 500))};
               2: value = CENTROID_W'($urandom());
               default: begin
                  case ($urandom_range(2))
                     0: value = '0;
                     1: value = CENTROID_ALL_ONES;
                     default: value = CENTROID_W'($urandom());
                  endcase
               end
            endcase
            write_centroid(CENTROID_CSR[k], value);
         end
         repeat (PHASE_REQUESTS) send_reading(random_reading());
         wait_for_responses();
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      repeat (150) send_reading(random_reading());
      idle_enable = 1'b1;
      wait_for_responses();
   endtask

   // The response side stops long enough for the pipeline to fill and
   // push back on the request side.
   task automatic test_response_backpressure();
      idle_enable   = 1'b0;
      rsp_hold_left = 80;
      repeat (60) send_reading(random_reading());
      idle_enable = 1'b1;
      wait_for_responses();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_class_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected response, class %0d", rsp_tdata[CLASS_W-1:0]);
            end
         end else if (rsp_tdata[CLASS_W-1:0] != expected_class_q[0]) begin
            error_count++;
            if (error_count <= 10) begin
               $display("color_class: expected %0d (%s), got %0d", expected_class_q[0],
                        expected_class_q[0].name(), rsp_tdata[CLASS_W-1:0]);
            end
            void'(expected_class_q.pop_front());
         end else begin
            void'(expected_class_q.pop_front());
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rgb_nearest_centroid_classifier: mismatch");
      $finish;
   end

   initial begin
      for (int k = 0; k < NUM_CENTROIDS; k++) centroid_model[k] = CENTROID_RESET[k];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_centroids();
      test_tie_break();
      test_centroid_extremes();
      test_unused_csr_index();
      test_random_centroids();
      test_back_to_back();
      test_response_backpressure();
      wait_for_responses();
      repeat (PIPE_SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("rgb_nearest_centroid_classifier: match");
      end else begin
         $display("rgb_nearest_centroid_classifier: mismatch");
      end
      $finish;
   end

endmodule
